// ===== sv/multi_axis_stepper_sequencer_top_defines.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the stepper sequencer
// Shared property wrappers used by the checker.
// ------------------------------------------------------------------------
`ifndef MULTI_AXIS_STEPPER_SEQUENCER_TOP_DEFINES_SVH
`define MULTI_AXIS_STEPPER_SEQUENCER_TOP_DEFINES_SVH

// Property checked outside reset only.
`define MASS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property checked on every edge, reset included.
`define MASS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== sv/mass_pkg.sv =====
// ------------------------------------------------------------------------
// mass_pkg
// Types, codes and constants of the stepper sequencer.
// ------------------------------------------------------------------------
package mass_pkg;

  localparam int MOTORS_DEF     = 4;
  localparam int STEP_FIELDS    = 4;   // motors that have a step field
  localparam int STEP_W         = 8;
  localparam int DELAY_W        = 20;
  localparam logic [DELAY_W-1:0] DELAY_RST = 20'd1000;
  localparam int S_TDATA_W      = 40;  // 4 x 8 step counts + 2 select, byte padded
  localparam int M_TDATA_W      = 8;   // 2 index + 4 pattern + 1 busy, byte padded

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TICK = 2'd1,
    REQ_STOP = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    EVT_COIL   = 2'd0,
    EVT_ACCEPT = 2'd1,
    EVT_REJECT = 2'd2,
    EVT_FINISH = 2'd3
  } evt_t;

  typedef struct packed {
    req_t                                req;
    logic [STEP_FIELDS-1:0][STEP_W-1:0]  steps;
    logic [1:0]                          sel;
  } item_t;

  typedef struct packed {
    logic       valid;
    evt_t       kind;
    logic [1:0] motor;
    logic [3:0] pattern;
    logic       busy;
  } result_t;

  // Full-step coil table, phases 0..3.
  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    logic [3:0] p;
    case (ph)
      2'd0:    p = 4'h9;
      2'd1:    p = 4'h3;
      2'd2:    p = 4'h6;
      2'd3:    p = 4'hC;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/mass_seq.sv =====
// ------------------------------------------------------------------------
// mass_seq
// Sequencer state and the single-pass update for one request.
// ------------------------------------------------------------------------
module mass_seq #(
  parameter int MOTORS = mass_pkg::MOTORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mass_pkg::DELAY_W-1:0] cfg_delay,
  input  logic                         fire,
  input  mass_pkg::item_t              item,
  output mass_pkg::result_t            res
);
  import mass_pkg::*;

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [1:0]         phase          [MOTORS];
  logic [1:0]         phase_next     [MOTORS];
  logic [STEP_W-1:0]  remaining      [MOTORS];
  logic [STEP_W-1:0]  remaining_next [MOTORS];
  logic               backward       [MOTORS];
  logic               backward_next  [MOTORS];
  logic [DELAY_W-1:0] wait_count, wait_count_next;
  logic [DELAY_W-1:0] step_delay;
  logic               running, running_next;

  logic               found;
  logic [IDX_W-1:0]   pick;
  logic [STEP_W-1:0]  cnt;

  // lowest motor with steps left
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < MOTORS; i++) begin
      if (!found && remaining[i] != '0) begin
        found = 1'b1;
        pick  = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      phase_next[i]     = phase[i];
      remaining_next[i] = remaining[i];
      backward_next[i]  = backward[i];
    end
    wait_count_next = wait_count;
    running_next    = running;
    cnt             = '0;
    res             = '0;
    res.kind        = EVT_COIL;

    case (item.req)
      REQ_LOAD: begin
        res.valid = 1'b1;
        if (running) begin
          res.kind = EVT_REJECT;
          res.busy = 1'b1;
        end else begin
          for (int i = 0; i < MOTORS; i++) begin
            cnt = '0;
            if (i < STEP_FIELDS) cnt = item.steps[i];
            backward_next[i]  = cnt[STEP_W-1];
            remaining_next[i] = cnt[STEP_W-1] ? STEP_W'(0 - cnt) : cnt;
          end
          wait_count_next = '0;
          running_next    = 1'b1;
          res.kind        = EVT_ACCEPT;
          res.busy        = 1'b1;
        end
      end
      REQ_TICK: begin
        if (running) begin
          if (wait_count != '0) begin
            wait_count_next = wait_count - DELAY_W'(1);
          end else if (found) begin
            for (int i = 0; i < MOTORS; i++) begin
              if (pick == IDX_W'(i)) begin
                phase_next[i]     = backward[i] ? phase[i] - 2'd1 : phase[i] + 2'd1;
                remaining_next[i] = remaining[i] - STEP_W'(1);
                res.pattern       = coil_of(phase[i]);
              end
            end
            wait_count_next = step_delay;
            res.valid       = 1'b1;
            res.kind        = EVT_COIL;
            res.motor       = 2'(pick);
            res.busy        = 1'b1;
          end else begin
            running_next = 1'b0;
            res.valid    = 1'b1;
            res.kind     = EVT_FINISH;
            res.busy     = 1'b0;
          end
        end
      end
      REQ_STOP: begin
        if (32'(item.sel) < MOTORS) begin
          res.valid = 1'b1;
          res.kind  = EVT_COIL;
          res.motor = item.sel;
          res.busy  = running;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        phase[i]     <= '0;
        remaining[i] <= '0;
        backward[i]  <= 1'b0;
      end
      wait_count <= '0;
      running    <= 1'b0;
      step_delay <= DELAY_RST;
    end else begin
      if (cfg_we) step_delay <= cfg_delay;
      if (fire) begin
        for (int i = 0; i < MOTORS; i++) begin
          phase[i]     <= phase_next[i];
          remaining[i] <= remaining_next[i];
          backward[i]  <= backward_next[i];
        end
        wait_count <= wait_count_next;
        running    <= running_next;
      end
    end
  end

endmodule

// ===== sv/multi_axis_stepper_sequencer_top.sv =====
// ------------------------------------------------------------------------
// multi_axis_stepper_sequencer_top
// Full-step coil sequencer for up to four bipolar steppers.
// ------------------------------------------------------------------------
// A load request (tuser 0) takes one signed step count per motor and starts a
// move; a load while a move runs is answered with a reject beat. Tick
// requests (tuser 1, one per microsecond) then run motor 0's steps, then
// motor 1's, and so on: each step emits the coil pattern of the motor's phase
// (9, 3, 6, C), moves the phase one way or the other and holds for
// step_delay ticks; the tick after the last hold yields a finish beat. A stop
// request (tuser 2) emits a zero pattern for one motor without touching the
// move. Ticks that only count down give no beat. Each beat is registered on
// entry, the state update is one pass of logic, and the result lands in an
// output register, so a new beat is taken every cycle while the output side
// keeps up. step_delay resets to 1000 and is written on the cfg channel,
// which is always ready.
// ------------------------------------------------------------------------
module multi_axis_stepper_sequencer_top #(
  parameter int MOTORS = mass_pkg::MOTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] steps_m0, [15:8] steps_m1, [23:16] steps_m2, [31:24] steps_m3,
  // [33:32] motor_select, rest zero
  input  logic [mass_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] motor_index, [5:2] coil_pattern, [6] busy_res, [7] zero
  output logic [mass_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mass_pkg::DELAY_W-1:0]   cfg_data
);
  import mass_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  logic    fire;
  result_t res;
  logic    out_valid;
  result_t out_res;

  // output register frees when empty or being taken
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.req   <= req_t'(s_axis_tuser);
      in_item.steps <= s_axis_tdata[STEP_FIELDS*STEP_W-1:0];
      in_item.sel   <= s_axis_tdata[STEP_FIELDS*STEP_W +: 2];
    end
  end

  mass_seq #(
    .MOTORS (MOTORS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_delay (cfg_data),
    .fire      (fire),
    .item      (in_item),
    .res       (res)
  );

  // result register; requests with no result just drain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {1'b0, out_res.busy, out_res.pattern, out_res.motor};

endmodule

// ===== sv/mass_checker.sv =====
// ------------------------------------------------------------------------
// mass_checker
// Port-level checks on the stepper sequencer, bound to the top level.
// ------------------------------------------------------------------------
`include "multi_axis_stepper_sequencer_top_defines.svh"

module mass_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mass_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           cfg_ready
);
  import mass_pkg::*;

  // stalled beat holds
  `MASS_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // nothing leaves straight after reset
  `MASS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid)

  // status beats carry no motor and no pattern
  `MASS_ASSERT(a_status_clean, clk, rst, m_axis_tvalid && m_axis_tuser != EVT_COIL |-> m_axis_tdata[5:0] == 6'd0)

  // accept and reject show busy, finish shows idle
  `MASS_ASSERT(a_busy_kind, clk, rst, m_axis_tvalid && (m_axis_tuser == EVT_ACCEPT || m_axis_tuser == EVT_REJECT) |-> m_axis_tdata[6])
  `MASS_ASSERT(a_finish_idle, clk, rst, m_axis_tvalid && m_axis_tuser == EVT_FINISH |-> !m_axis_tdata[6] && cfg_ready)

endmodule

bind multi_axis_stepper_sequencer_top mass_checker u_mass_checker (.*);
